>>> rtl/core/gwr_pkg.sv
// Shared types and constants for the Givens wavefront rotation core.
// Used by the lane cells, the sequencer, the result queue and the top level.
// No dependencies.
package gwr_pkg;

   localparam int ELEM_W      = 32;
   localparam int COEF_W      = 18;
   localparam int FRAC_W      = 16;
   localparam int NUM_COEF    = 6;
   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_W      = 2;
   localparam int PROD_W      = ELEM_W + COEF_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int MAX_RESULTS = 4;
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = 3;
   localparam int RSP_CNT_W   = 4;
   localparam int INFL_W      = 3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ROT,
      OP_EMIT,
      OP_SHIFT
   } op_kind_type;

   typedef struct packed {
      logic                     valid;
      op_kind_type              kind;
      logic [SLOT_W-1:0]        slot_x;
      logic [SLOT_W-1:0]        slot_y;
      logic signed [COEF_W-1:0] gamma;
      logic signed [COEF_W-1:0] sigma;
      logic                     eop;
   } op_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_ISSUE
   } seq_state_type;

   typedef enum logic [3:0] {
      PC_LOAD,
      PC_ROT_W0,
      PC_ROT_W1,
      PC_ROT_W2,
      PC_EMIT_OLD,
      PC_SHIFT,
      PC_FLUSH_W1,
      PC_FLUSH_W2A,
      PC_FLUSH_W2B,
      PC_DRAIN_0,
      PC_DRAIN_1,
      PC_DRAIN_2
   } step_type;

endpackage

>>> rtl/core/gwr_delay.sv
// Fixed-length register delay line, used to skew column data into the cell
// chain and to realign lane results coming out of it. No package use.
module gwr_delay #(
   parameter int DEPTH = 1,
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   if (DEPTH == 0) begin : g_direct
      assign dout = din;
   end else begin : g_line
      logic [WIDTH-1:0] line_ff [DEPTH];

      always_ff @(posedge clock) begin
         line_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end

      assign dout = line_ff[DEPTH-1];
   end

endmodule

>>> rtl/core/gwr_cell.sv
// One lane cell of the rotation chain: holds this row's pending columns and
// runs load, rotate, emit and shift operations, passing each op onward.
// Depends on gwr_pkg.
module gwr_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  gwr_pkg::op_type            op_in,
   input  logic [gwr_pkg::ELEM_W-1:0] load_elem,
   output gwr_pkg::op_type            op_out,
   output logic                       emit_valid,
   output logic                       emit_eop,
   output logic [gwr_pkg::ELEM_W-1:0] emit_data
);
   import gwr_pkg::*;

   localparam int SHR_W = SUM_W - FRAC_W;
   localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   function automatic logic signed [ELEM_W-1:0] shift_sat(input logic signed [SUM_W-1:0] v);
      logic [SHR_W-1:0] r;
      logic signed [ELEM_W-1:0] res;
      r = v[SUM_W-1:FRAC_W];
      if (r[SHR_W-1:ELEM_W-1] == '0 || r[SHR_W-1:ELEM_W-1] == '1) begin
         res = r[ELEM_W-1:0];
      end else if (r[SHR_W-1]) begin
         res = SAT_MIN;
      end else begin
         res = SAT_MAX;
      end
      return res;
   endfunction

   op_type                   op_ff;
   op_type                   op2_ff;
   logic signed [ELEM_W-1:0] slot_ff [NUM_SLOTS];
   logic signed [ELEM_W-1:0] slot_in [NUM_SLOTS];
   logic signed [PROD_W-1:0] prod_cx_ff;
   logic signed [PROD_W-1:0] prod_sy_ff;
   logic signed [PROD_W-1:0] prod_cy_ff;
   logic signed [PROD_W-1:0] prod_sx_ff;
   logic signed [ELEM_W-1:0] read_ff;
   logic signed [ELEM_W-1:0] x_val;
   logic signed [ELEM_W-1:0] y_val;
   logic signed [SUM_W-1:0]  sum_x;
   logic signed [SUM_W-1:0]  sum_y;

   assign x_val = slot_ff[op_ff.slot_x];
   assign y_val = slot_ff[op_ff.slot_y];
   assign sum_x = {prod_cx_ff[PROD_W-1], prod_cx_ff} + {prod_sy_ff[PROD_W-1], prod_sy_ff};
   assign sum_y = {prod_cy_ff[PROD_W-1], prod_cy_ff} - {prod_sx_ff[PROD_W-1], prod_sx_ff};

   always_comb begin
      slot_in = slot_ff;
      if (op_ff.valid) begin
         unique case (op_ff.kind)
            OP_LOAD: begin
               slot_in[op_ff.slot_x] = load_elem;
            end
            OP_SHIFT: begin
               for (int k = 0; k < NUM_SLOTS - 1; k++) begin
                  slot_in[k] = slot_ff[k+1];
               end
            end
            OP_ROT: begin
            end
            OP_EMIT: begin
            end
         endcase
      end
      // write back the rotated pair
      if (op2_ff.valid && op2_ff.kind == OP_ROT) begin
         slot_in[op2_ff.slot_x] = shift_sat(sum_x);
         slot_in[op2_ff.slot_y] = shift_sat(sum_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= '0;
         op2_ff <= '0;
      end else begin
         op_ff  <= op_in;
         op2_ff <= op_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      prod_cx_ff <= op_ff.gamma * x_val;
      prod_sy_ff <= op_ff.sigma * y_val;
      prod_cy_ff <= op_ff.gamma * y_val;
      prod_sx_ff <= op_ff.sigma * x_val;
      read_ff    <= x_val;
   end

   assign op_out     = op_ff;
   assign emit_valid = op2_ff.valid && op2_ff.kind == OP_EMIT;
   assign emit_eop   = op2_ff.eop;
   assign emit_data  = read_ff;

endmodule

>>> rtl/core/gwr_seq.sv
// Operation sequencer: keeps the pending-column count and coefficient history
// and issues the per-column operation list into the cell chain.
// Depends on gwr_pkg.
module gwr_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic [gwr_pkg::NUM_COEF*gwr_pkg::COEF_W-1:0] req_coef,
   input  logic                                   req_last,
   input  logic [gwr_pkg::RSP_CNT_W-1:0]          rsp_count,
   input  logic                                   rsp_push,
   output logic                                   req_tready,
   output gwr_pkg::op_type                        op_out
);
   import gwr_pkg::*;

   localparam int K_G0 = 0;
   localparam int K_S0 = 1;
   localparam int K_G1 = 2;
   localparam int K_S1 = 3;
   localparam int K_G2 = 4;
   localparam int K_S2 = 5;
   localparam int OCC_W = RSP_CNT_W + 1;
   localparam logic [SLOT_W-1:0] FULL_SEEN = SLOT_W'(NUM_SLOTS - 1);

   seq_state_type            state_ff, state_in;
   step_type                 pc_ff, pc_in;
   logic                     gap_ff, gap_in;
   logic [SLOT_W-1:0]        seen_ff, seen_in;
   logic [INFL_W-1:0]        inflight_ff, inflight_in;
   logic signed [COEF_W-1:0] hist_ff [3][NUM_COEF];
   logic signed [COEF_W-1:0] hist_in [3][NUM_COEF];
   logic signed [COEF_W-1:0] coef_ff [NUM_COEF];
   logic                     fin_ff;
   op_type                   op_ff, op_in;
   op_type                   cand;
   logic                     applicable;
   logic                     issue_emit;
   logic                     accept;
   logic [SLOT_W-1:0]        m_slot, m_prev, m_prev2, s_prev, s_prev2;
   logic [OCC_W-1:0]         occupancy;

   assign m_slot  = (seen_ff == FULL_SEEN) ? SLOT_W'(NUM_SLOTS - 2) : seen_ff;
   assign m_prev  = m_slot - SLOT_W'(1);
   assign m_prev2 = m_slot - SLOT_W'(2);
   assign s_prev  = seen_ff - SLOT_W'(1);
   assign s_prev2 = seen_ff - SLOT_W'(2);

   assign occupancy  = OCC_W'(rsp_count) + OCC_W'(inflight_ff);
   assign req_tready = (state_ff == SEQ_IDLE) &&
                       (occupancy <= OCC_W'(RSP_DEPTH - MAX_RESULTS));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cand       = '0;
      cand.kind  = OP_LOAD;
      applicable = 1'b0;
      unique case (pc_ff)
         PC_LOAD: begin
            applicable  = 1'b1;
            cand.kind   = OP_LOAD;
            cand.slot_x = seen_ff;
         end
         PC_ROT_W0: begin
            applicable  = seen_ff >= SLOT_W'(1);
            cand.kind   = OP_ROT;
            cand.slot_x = s_prev;
            cand.slot_y = seen_ff;
            cand.gamma  = hist_ff[0][K_G0];
            cand.sigma  = hist_ff[0][K_S0];
         end
         PC_ROT_W1: begin
            applicable  = seen_ff >= SLOT_W'(2);
            cand.kind   = OP_ROT;
            cand.slot_x = s_prev2;
            cand.slot_y = s_prev;
            cand.gamma  = hist_ff[1][K_G1];
            cand.sigma  = hist_ff[1][K_S1];
         end
         PC_ROT_W2: begin
            applicable  = seen_ff == FULL_SEEN;
            cand.kind   = OP_ROT;
            cand.slot_x = SLOT_W'(0);
            cand.slot_y = SLOT_W'(1);
            cand.gamma  = hist_ff[2][K_G2];
            cand.sigma  = hist_ff[2][K_S2];
         end
         PC_EMIT_OLD: begin
            applicable  = seen_ff == FULL_SEEN;
            cand.kind   = OP_EMIT;
            cand.slot_x = SLOT_W'(0);
         end
         PC_SHIFT: begin
            applicable = seen_ff == FULL_SEEN;
            cand.kind  = OP_SHIFT;
         end
         PC_FLUSH_W1: begin
            applicable  = fin_ff && seen_ff >= SLOT_W'(1);
            cand.kind   = OP_ROT;
            cand.slot_x = m_prev;
            cand.slot_y = m_slot;
            cand.gamma  = hist_ff[0][K_G1];
            cand.sigma  = hist_ff[0][K_S1];
         end
         PC_FLUSH_W2A: begin
            applicable  = fin_ff && seen_ff >= SLOT_W'(2);
            cand.kind   = OP_ROT;
            cand.slot_x = m_prev2;
            cand.slot_y = m_prev;
            cand.gamma  = hist_ff[1][K_G2];
            cand.sigma  = hist_ff[1][K_S2];
         end
         PC_FLUSH_W2B: begin
            applicable  = fin_ff && seen_ff >= SLOT_W'(1);
            cand.kind   = OP_ROT;
            cand.slot_x = m_prev;
            cand.slot_y = m_slot;
            cand.gamma  = hist_ff[0][K_G2];
            cand.sigma  = hist_ff[0][K_S2];
         end
         PC_DRAIN_0: begin
            applicable  = fin_ff;
            cand.kind   = OP_EMIT;
            cand.slot_x = SLOT_W'(0);
            cand.eop    = m_slot == SLOT_W'(0);
         end
         PC_DRAIN_1: begin
            applicable  = fin_ff && m_slot >= SLOT_W'(1);
            cand.kind   = OP_EMIT;
            cand.slot_x = SLOT_W'(1);
            cand.eop    = m_slot == SLOT_W'(1);
         end
         PC_DRAIN_2: begin
            applicable  = fin_ff && m_slot == SLOT_W'(2);
            cand.kind   = OP_EMIT;
            cand.slot_x = SLOT_W'(2);
            cand.eop    = 1'b1;
         end
         default: begin
            applicable = 1'b0;
         end
      endcase
      cand.valid = applicable;
   end

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      gap_in     = 1'b0;
      seen_in    = seen_ff;
      hist_in    = hist_ff;
      op_in      = cand;
      op_in.valid = 1'b0;
      issue_emit = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_ISSUE;
               pc_in    = PC_LOAD;
            end
         end
         SEQ_ISSUE: begin
            if (!gap_ff) begin
               op_in      = cand;
               gap_in     = applicable;
               issue_emit = applicable && cand.kind == OP_EMIT;
               if ((pc_ff == PC_SHIFT && !fin_ff) || pc_ff == PC_DRAIN_2) begin
                  state_in = SEQ_IDLE;
                  if (fin_ff) begin
                     seen_in = '0;
                  end else begin
                     seen_in    = m_slot + SLOT_W'(1);
                     hist_in[2] = hist_ff[1];
                     hist_in[1] = hist_ff[0];
                     for (int k = 0; k < NUM_COEF; k++) begin
                        hist_in[0][k] = coef_ff[k];
                     end
                  end
               end else begin
                  pc_in = step_type'(pc_ff + 4'd1);
               end
            end
         end
      endcase
   end

   always_comb begin
      inflight_in = inflight_ff;
      unique case ({issue_emit, rsp_push})
         2'b10:   inflight_in = inflight_ff + INFL_W'(1);
         2'b01:   inflight_in = inflight_ff - INFL_W'(1);
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_IDLE;
         pc_ff       <= PC_LOAD;
         gap_ff      <= 1'b0;
         seen_ff     <= '0;
         inflight_ff <= '0;
         op_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         pc_ff       <= pc_in;
         gap_ff      <= gap_in;
         seen_ff     <= seen_in;
         inflight_ff <= inflight_in;
         op_ff       <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      if (accept) begin
         fin_ff <= req_last;
         for (int k = 0; k < NUM_COEF; k++) begin
            coef_ff[k] <= req_coef[k*COEF_W +: COEF_W];
         end
      end
   end

   assign op_out = op_ff;

endmodule

>>> rtl/core/gwr_rsp_fifo.sv
// Result queue between the cell chain and the result channel.
// Depends on gwr_pkg for its depth and pointer widths.
module gwr_rsp_fifo #(
   parameter int WIDTH = 129
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic                          out_valid,
   output logic [WIDTH-1:0]              out_data,
   output logic [gwr_pkg::RSP_CNT_W-1:0] count
);
   import gwr_pkg::*;

   logic [WIDTH-1:0]     mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + RSP_CNT_W'(1);
            2'b01:   count_ff <= count_ff - RSP_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = mem[rd_ptr_ff];
   assign count     = count_ff;

endmodule

>>> rtl/core/givens_wave_rotation_apply_core.sv
// Top level of the Givens wavefront rotation core: sequencer, lane cell chain,
// data skew lines and result queue. Depends on gwr_pkg and all gwr_* modules.
//
//   channel | handshake                | payload
//   req     | req_tvalid / req_tready  | req_tdata: rows, six Q1.16 coefs; req_tlast: last column
//   rsp     | rsp_tvalid / rsp_tready  | rsp_tdata: rows of finished column; rsp_tlast: end of panel
//
// Each load, rotate, emit or shift that applies is followed by an idle gap
// for the multiply and write-back loop of the lane cells; an operation that
// does not apply is skipped with no gap.
// Synchronous active-high reset clears control state; no clearing pass.
// Results wait in an 8-entry queue; req_tready falls while it cannot take
// four more results, so a stalled result channel stalls the input.
module givens_wave_rotation_apply_core #(
   parameter int LANES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // lanes of 32 bits from row 0 up, then cos/sin first, second, third (18 bits), zero pad
   input  logic [((LANES*gwr_pkg::ELEM_W + gwr_pkg::NUM_COEF*gwr_pkg::COEF_W + 7)/8)*8-1:0]
                                req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // lanes of 32 bits from row 0 up
   output logic [LANES*gwr_pkg::ELEM_W-1:0] rsp_tdata,
   output logic                 rsp_tlast
);
   import gwr_pkg::*;

   localparam int COL_W = LANES * ELEM_W;
   localparam int RSP_W = COL_W + 1;

   logic                 req_accept;
   logic                 rsp_pop;
   logic [ELEM_W-1:0]    col_ff [LANES];
   logic [ELEM_W-1:0]    load_elem [LANES];
   logic [ELEM_W-1:0]    emit_data [LANES];
   logic [ELEM_W-1:0]    aligned [LANES];
   logic                 emit_valid [LANES];
   logic                 emit_eop [LANES];
   op_type               op_link [LANES+1];
   logic                 fifo_push;
   logic [RSP_W-1:0]     fifo_in;
   logic [RSP_W-1:0]     fifo_out;
   logic [RSP_CNT_W-1:0] rsp_count;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int r = 0; r < LANES; r++) begin
            col_ff[r] <= req_tdata[r*ELEM_W +: ELEM_W];
         end
      end
   end

   gwr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_coef   (req_tdata[COL_W +: NUM_COEF*COEF_W]),
      .req_last   (req_tlast),
      .rsp_count  (rsp_count),
      .rsp_push   (fifo_push),
      .req_tready (req_tready),
      .op_out     (op_link[0])
   );

   for (genvar lane = 0; lane < LANES; lane++) begin : g_lane
      gwr_delay #(
         .DEPTH (lane),
         .WIDTH (ELEM_W)
      ) u_in_skew (
         .clock (clock),
         .din   (col_ff[lane]),
         .dout  (load_elem[lane])
      );

      gwr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op_in      (op_link[lane]),
         .load_elem  (load_elem[lane]),
         .op_out     (op_link[lane+1]),
         .emit_valid (emit_valid[lane]),
         .emit_eop   (emit_eop[lane]),
         .emit_data  (emit_data[lane])
      );

      gwr_delay #(
         .DEPTH (LANES - 1 - lane),
         .WIDTH (ELEM_W)
      ) u_out_align (
         .clock (clock),
         .din   (emit_data[lane]),
         .dout  (aligned[lane])
      );

      assign fifo_in[lane*ELEM_W +: ELEM_W] = aligned[lane];
   end

   assign fifo_push      = emit_valid[LANES-1];
   assign fifo_in[COL_W] = emit_eop[LANES-1];

   gwr_rsp_fifo #(
      .WIDTH (RSP_W)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in),
      .pop       (rsp_pop),
      .out_valid (rsp_tvalid),
      .out_data  (fifo_out),
      .count     (rsp_count)
   );

   assign rsp_tdata = fifo_out[COL_W-1:0];
   assign rsp_tlast = fifo_out[COL_W];

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (rsp_count != RSP_CNT_W'(RSP_DEPTH) || rsp_pop))
      else $error("result queue written while full");

   a_op_spacing_head: assert property (@(posedge clock) disable iff (reset)
      op_link[0].valid |=> !op_link[0].valid)
      else $error("operations issued back to back into the cell chain");

   a_op_spacing_tail: assert property (@(posedge clock) disable iff (reset)
      op_link[LANES].valid |=> !op_link[LANES].valid)
      else $error("operation spacing lost along the cell chain");

endmodule
